// File: hw/rtl/brcp_pkg.sv
// Shared types and constants for the block read cache planner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package brcp_pkg;

   localparam int DEF_CACHE_ENTRIES = 8;
   localparam int DEF_BLOCK_BITS    = 12;
   localparam int MAX_BLOCK_BITS    = 16;

   localparam int ADDR_W   = 32;
   localparam int SLOT_W   = 3;
   localparam int BOFF_W   = 12;
   localparam int SBITS_W  = 4;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FS_SIZE     = 2'd0,
      CSR_SECTOR_BITS = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_EMPTY  = 2'd0,
      KIND_HIT    = 2'd1,
      KIND_FILL   = 2'd2,
      KIND_DIRECT = 2'd3
   } seg_kind_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_CLAMP,
      F_HEAD,
      F_MID,
      F_TAIL
   } front_state_type;

   // One planned segment; cache segments carry KIND_FILL until the back end looks them up
   typedef struct packed {
      seg_kind_type              kind;
      logic [ADDR_W-1:0]         sector;
      logic [MAX_BLOCK_BITS-1:0] offset;
      logic [ADDR_W-1:0]         length;
      logic [ADDR_W-1:0]         dest;
      logic                      last;
   } seg_type;

   typedef struct packed {
      logic    valid;
      seg_type seg;
   } seg_push_type;

endpackage

// File: hw/rtl/brcp_seg_queue.sv
// Short segment queue between the planner front end and the cache back end.
// Depends on brcp_pkg.
`timescale 1ns / 1ps
module brcp_seg_queue
   import brcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seg_push_type push,
   input  logic         pop,
   output seg_type      head,
   output logic         empty,
   output logic         full
);

   seg_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.seg;
      end
   end

endmodule

// File: hw/rtl/brcp_front.sv
// Planner front end: holds configuration, clamps each request and splits it
// into head, direct middle and tail segments, or one empty result. Depends on brcp_pkg.
`timescale 1ns / 1ps
module brcp_front
   import brcp_pkg::*;
#(
   parameter int BLOCK_BITS = DEF_BLOCK_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ADDR_W-1:0]    byte_pos,
   input  logic [ADDR_W-1:0]    byte_count,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   input  logic                 queue_full,
   output seg_push_type         push,
   output logic                 idle
);

   localparam int SHIFT_W = $clog2(BLOCK_BITS + 1);
   localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'((64'd1 << BLOCK_BITS) - 64'd1);
   localparam logic [BLOCK_BITS:0] BLOCK_SIZE = (BLOCK_BITS + 1)'(64'd1 << BLOCK_BITS);

   front_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]        fs_size_ff, fs_size_in;
   logic [SBITS_W-1:0]       sector_bits_ff, sector_bits_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [ADDR_W-1:0]        left_ff, left_in;
   logic [ADDR_W-1:0]        dest_ff, dest_in;
   logic [ADDR_W-1:0]        sector_ff, sector_in;
   logic [BLOCK_BITS-1:0]    offset_ff, offset_in;
   logic [SHIFT_W-1:0]       shift_ff, shift_in;

   logic [SHIFT_W-1:0]       sb;
   logic [ADDR_W:0]          end_pos;
   logic                     is_empty;
   logic [BLOCK_BITS:0]      room;
   logic [ADDR_W-1:0]        head_chunk;
   logic [ADDR_W-1:0]        mid_chunk;

   assign idle = (state_ff == F_IDLE);

   // Configuration writes; the user must write only while the block is idle, the block itself does not enforce it
   always_comb begin
      fs_size_in     = fs_size_ff;
      sector_bits_in = sector_bits_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FS_SIZE:     fs_size_in     = csr_wdata;
            CSR_SECTOR_BITS: sector_bits_in = csr_wdata[SBITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // clamp sector size to the block size
      if (32'(sector_bits_ff) > BLOCK_BITS) begin
         sb = SHIFT_W'(BLOCK_BITS);
      end else begin
         sb = SHIFT_W'(sector_bits_ff);
      end
      end_pos    = {1'b0, pos_ff} + {1'b0, left_ff};
      is_empty   = (pos_ff >= fs_size_ff) || (left_ff == '0);
      room       = BLOCK_SIZE - {1'b0, offset_ff};
      head_chunk = (left_ff <= ADDR_W'(room)) ? left_ff : ADDR_W'(room);
      mid_chunk  = left_ff & ~LOW_MASK;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      dest_in   = dest_ff;
      sector_in = sector_ff;
      offset_in = offset_ff;
      shift_in  = shift_ff;
      push      = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               pos_in   = byte_pos;
               left_in  = byte_count;
               state_in = F_CLAMP;
            end
         end
         F_CLAMP: begin
            shift_in  = SHIFT_W'(BLOCK_BITS) - sb;
            sector_in = (pos_ff >> BLOCK_BITS) << (SHIFT_W'(BLOCK_BITS) - sb);
            offset_in = pos_ff[BLOCK_BITS-1:0];
            dest_in   = '0;
            if (is_empty) begin
               push.valid    = 1'b1;
               push.seg.kind = KIND_EMPTY;
               push.seg.last = 1'b1;
               if (!queue_full) begin
                  state_in = F_IDLE;
               end
            end else begin
               if (end_pos > {1'b0, fs_size_ff}) begin
                  left_in = fs_size_ff - pos_ff;
               end
               state_in = F_HEAD;
            end
         end
         F_HEAD: begin
            if (offset_ff == '0) begin
               state_in = F_MID;
            end else begin
               push.valid       = 1'b1;
               push.seg.kind    = KIND_FILL;
               push.seg.sector  = sector_ff;
               push.seg.offset  = MAX_BLOCK_BITS'(offset_ff);
               push.seg.length  = head_chunk;
               push.seg.dest    = dest_ff;
               push.seg.last    = (left_ff == head_chunk);
               if (!queue_full) begin
                  left_in   = left_ff - head_chunk;
                  dest_in   = dest_ff + head_chunk;
                  sector_in = sector_ff + (ADDR_W'(1) << shift_ff);
                  state_in  = F_MID;
               end
            end
         end
         F_MID: begin
            if (mid_chunk == '0) begin
               state_in = F_TAIL;
            end else begin
               push.valid      = 1'b1;
               push.seg.kind   = KIND_DIRECT;
               push.seg.sector = sector_ff;
               push.seg.length = mid_chunk;
               push.seg.dest   = dest_ff;
               push.seg.last   = ((left_ff & LOW_MASK) == '0);
               if (!queue_full) begin
                  left_in   = left_ff & LOW_MASK;
                  dest_in   = dest_ff + mid_chunk;
                  sector_in = sector_ff + ((left_ff >> BLOCK_BITS) << shift_ff);
                  state_in  = F_TAIL;
               end
            end
         end
         F_TAIL: begin
            if (left_ff == '0) begin
               state_in = F_IDLE;
            end else begin
               push.valid      = 1'b1;
               push.seg.kind   = KIND_FILL;
               push.seg.sector = sector_ff;
               push.seg.length = left_ff;
               push.seg.dest   = dest_ff;
               push.seg.last   = 1'b1;
               if (!queue_full) begin
                  state_in = F_IDLE;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         fs_size_ff     <= '0;
         sector_bits_ff <= SBITS_W'(9);
      end else begin
         state_ff       <= state_in;
         fs_size_ff     <= fs_size_in;
         sector_bits_ff <= sector_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      dest_ff   <= dest_in;
      sector_ff <= sector_in;
      offset_ff <= offset_in;
      shift_ff  <= shift_in;
   end

endmodule

// File: hw/rtl/brcp_back.sv
// Cache back end: looks up segment tags in a fully associative tag store,
// fills on a miss under a round-robin pointer and drives results. Depends on brcp_pkg.
`timescale 1ns / 1ps
module brcp_back
   import brcp_pkg::*;
#(
   parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  seg_type           head,
   input  logic              queue_empty,
   output logic              pop,
   output logic              busy,
   output logic              rsp_valid,
   output logic [1:0]        rsp_segment_kind,
   output logic [ADDR_W-1:0] rsp_device_sector,
   output logic [SLOT_W-1:0] rsp_cache_slot,
   output logic [BOFF_W-1:0] rsp_block_offset,
   output logic [ADDR_W-1:0] rsp_seg_length,
   output logic [ADDR_W-1:0] rsp_dest_offset,
   output logic              rsp_last
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   logic [ADDR_W-1:0]        tag_ff [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic                     look_ff, look_in;
   seg_type                  seg_ff;
   logic [CACHE_ENTRIES-1:0] match_ff, match_in;

   logic                     out_valid_ff, out_valid_in;
   seg_kind_type             out_kind_ff, out_kind_in;
   logic [ADDR_W-1:0]        out_sector_ff;
   logic [IDX_W-1:0]         out_slot_ff, out_slot_in;
   logic [MAX_BLOCK_BITS-1:0] out_offset_ff;
   logic [ADDR_W-1:0]        out_length_ff;
   logic [ADDR_W-1:0]        out_dest_ff;
   logic                     out_last_ff;

   logic                     hit;
   logic [IDX_W-1:0]         hit_slot;
   logic                     do_fill;
   logic [31:0]              slot_wide;

   assign pop  = !look_ff && !queue_empty;
   assign busy = look_ff;

   always_comb begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == head.sector);
      end
   end

   // lowest matching entry wins
   always_comb begin
      hit      = |match_ff;
      hit_slot = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_slot = IDX_W'(i);
         end
      end
   end

   always_comb begin
      look_in      = pop;
      valid_in     = valid_ff;
      ptr_in       = ptr_ff;
      do_fill      = 1'b0;
      out_valid_in = look_ff;
      out_kind_in  = seg_ff.kind;
      out_slot_in  = '0;
      if (look_ff && (seg_ff.kind == KIND_FILL)) begin
         if (hit) begin
            out_kind_in = KIND_HIT;
            out_slot_in = hit_slot;
         end else begin
            do_fill          = 1'b1;
            out_kind_in      = KIND_FILL;
            out_slot_in      = ptr_ff;
            valid_in[ptr_ff] = 1'b1;
            ptr_in = (ptr_ff >= IDX_W'(CACHE_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         ptr_ff       <= '0;
         look_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         look_ff      <= look_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         seg_ff   <= head;
         match_ff <= match_in;
      end
      if (do_fill) begin
         tag_ff[ptr_ff] <= seg_ff.sector;
      end
      out_kind_ff   <= out_kind_in;
      out_sector_ff <= seg_ff.sector;
      out_slot_ff   <= out_slot_in;
      out_offset_ff <= seg_ff.offset;
      out_length_ff <= seg_ff.length;
      out_dest_ff   <= seg_ff.dest;
      out_last_ff   <= seg_ff.last;
   end

   assign slot_wide         = 32'(out_slot_ff);
   assign rsp_valid         = out_valid_ff;
   assign rsp_segment_kind  = out_kind_ff;
   assign rsp_device_sector = out_sector_ff;
   assign rsp_cache_slot    = slot_wide[SLOT_W-1:0];
   assign rsp_block_offset  = out_offset_ff[BOFF_W-1:0];
   assign rsp_seg_length    = out_length_ff;
   assign rsp_dest_offset   = out_dest_ff;
   assign rsp_last          = out_last_ff;

endmodule

// File: hw/rtl/block_read_cache_planner.sv
// Top level of the block read cache planner: front end, segment queue, back end.
// Depends on brcp_pkg, brcp_front, brcp_seg_queue and brcp_back.
//
// Usage: raise start with req_byte_pos and req_byte_count; the request is
// taken at a clock edge where start is high and busy is low. The request is
// clamped to the image size and planned as up to three segments (cached
// head, direct middle, cached tail), or one empty result when nothing is
// left to read. Each result shows on the rsp_ ports for one cycle with
// rsp_valid high; rsp_last marks the final one of a request.
// Back end: it compares all stored tags in parallel as it pops a segment,
// then does priority select and fill and registers the output; it pops the
// next segment only after the previous one has been looked up. busy stays
// high until the last result of a request is in the output register.
// Configuration: csr_write_en, csr_index, csr_wdata write fs_size_bytes
// (index 0) or sector_bits (index 1) at once; write only while busy is low.
// Reset: synchronous; clears all tag valid bits, the replace pointer, the
// queue and the configuration (size 0, sector_bits 9). Results cannot be
// held off by the receiver.
`timescale 1ns / 1ps
module block_read_cache_planner
   import brcp_pkg::*;
#(
   parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
   parameter int BLOCK_BITS    = DEF_BLOCK_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ADDR_W-1:0]    req_byte_pos,
   input  logic [ADDR_W-1:0]    req_byte_count,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_segment_kind,
   output logic [ADDR_W-1:0]    rsp_device_sector,
   output logic [SLOT_W-1:0]    rsp_cache_slot,
   output logic [BOFF_W-1:0]    rsp_block_offset,
   output logic [ADDR_W-1:0]    rsp_seg_length,
   output logic [ADDR_W-1:0]    rsp_dest_offset,
   output logic                 rsp_last
);

   seg_push_type push;
   seg_type      head;
   logic         queue_empty;
   logic         queue_full;
   logic         pop;
   logic         front_idle;
   logic         back_busy;
   logic         accept;

   assign busy   = !front_idle || !queue_empty || back_busy;
   assign accept = start && !busy;

   brcp_front #(
      .BLOCK_BITS (BLOCK_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_pos     (req_byte_pos),
      .byte_count   (req_byte_count),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_full   (queue_full),
      .push         (push),
      .idle         (front_idle)
   );

   brcp_seg_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .empty (queue_empty),
      .full  (queue_full)
   );

   brcp_back #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .queue_empty       (queue_empty),
      .pop               (pop),
      .busy              (back_busy),
      .rsp_valid         (rsp_valid),
      .rsp_segment_kind  (rsp_segment_kind),
      .rsp_device_sector (rsp_device_sector),
      .rsp_cache_slot    (rsp_cache_slot),
      .rsp_block_offset  (rsp_block_offset),
      .rsp_seg_length    (rsp_seg_length),
      .rsp_dest_offset   (rsp_dest_offset),
      .rsp_last          (rsp_last)
   );

endmodule

// File: tb/block_read_cache_planner_tb.sv
// Self-checking testbench for block_read_cache_planner: read splitting and cache tag lookups.
// Holds its own model of the tag store and the segment planner; needs brcp_pkg and the RTL.
`timescale 1ns / 1ps
module block_read_cache_planner_tb
   import brcp_pkg::*;
();

   localparam int ENTRIES = DEF_CACHE_ENTRIES;
   localparam int BLK     = DEF_BLOCK_BITS;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      seg_kind_type      kind;
      logic [ADDR_W-1:0] sector;
      logic [SLOT_W-1:0] slot;
      logic [BOFF_W-1:0] boff;
      logic [ADDR_W-1:0] len;
      logic [ADDR_W-1:0] dest;
      logic              last;
   } segment_type;

   typedef struct packed {
      bit                   is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [ADDR_W-1:0]    a;
      logic [ADDR_W-1:0]    b;
      bit                   typed;
      segment_type          want;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ADDR_W-1:0]    req_byte_pos;
   logic [ADDR_W-1:0]    req_byte_count;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;
   logic                 rsp_valid;
   logic [1:0]           rsp_segment_kind;
   logic [ADDR_W-1:0]    rsp_device_sector;
   logic [SLOT_W-1:0]    rsp_cache_slot;
   logic [BOFF_W-1:0]    rsp_block_offset;
   logic [ADDR_W-1:0]    rsp_seg_length;
   logic [ADDR_W-1:0]    rsp_dest_offset;
   logic                 rsp_last;

   block_read_cache_planner DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_byte_pos(req_byte_pos), .req_byte_count(req_byte_count),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_segment_kind(rsp_segment_kind),
      .rsp_device_sector(rsp_device_sector), .rsp_cache_slot(rsp_cache_slot),
      .rsp_block_offset(rsp_block_offset), .rsp_seg_length(rsp_seg_length),
      .rsp_dest_offset(rsp_dest_offset), .rsp_last(rsp_last)
   );

   // model state of the planner
   logic [ADDR_W-1:0]  tag_store [ENTRIES];
   bit                 tag_valid [ENTRIES];
   int                 fill_ptr;
   logic [ADDR_W-1:0]  fs_size;
   logic [SBITS_W-1:0] sect_bits;
   segment_type        planned [3];

   segment_type pending_segs [$];
   dir_row_type dir_rows [$];
   int          mismatches;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [SLOT_W-1:0] cache_lookup(input logic [ADDR_W-1:0] tag,
                                                      output seg_kind_type kind);
      int i;
      int hit;
      hit = -1;
      for (i = 0; i < ENTRIES; i++)
         if (hit < 0 && tag_valid[i] && tag_store[i] == tag) hit = i;
      if (hit >= 0) begin
         kind = KIND_HIT;
         return hit[SLOT_W-1:0];
      end
      hit = fill_ptr;
      tag_store[hit] = tag;
      tag_valid[hit] = 1'b1;
      fill_ptr = (hit + 1 >= ENTRIES) ? 0 : hit + 1;
      kind = KIND_FILL;
      return hit[SLOT_W-1:0];
   endfunction

   // Split one read into head / direct middle / tail and update the tag store.
   function automatic int plan_read(input logic [ADDR_W-1:0] pos32,
                                    input logic [ADDR_W-1:0] count32);
      logic [63:0]       p, c, size, left, dest, off, room, chunk, blocks;
      int                sb, shift, n;
      logic [ADDR_W-1:0] sector;
      seg_kind_type      kind;
      logic [SLOT_W-1:0] slot;
      p = {32'd0, pos32};
      c = {32'd0, count32};
      size = {32'd0, fs_size};
      n = 0;
      if (p >= size || c == 0) begin
         planned[0] = '{KIND_EMPTY, '0, '0, '0, '0, '0, 1'b1};
         return 1;
      end
      if (p + c > size) c = size - p;
      left = c;
      dest = 0;
      sb = (sect_bits > BLK) ? BLK : int'(sect_bits);
      shift = BLK - sb;
      sector = 32'(((p >> BLK) << shift));
      off = p & ((64'd1 << BLK) - 1);
      if (off != 0) begin
         room = (64'd1 << BLK) - off;
         chunk = (left <= room) ? left : room;
         slot = cache_lookup(sector, kind);
         planned[n] = '{kind, sector, slot, off[BOFF_W-1:0], chunk[31:0], dest[31:0], 1'b0};
         n = n + 1;
         left -= chunk;
         dest += chunk;
         sector = sector + 32'(64'd1 << shift);
      end
      if ((left >> BLK) != 0) begin
         blocks = left >> BLK;
         chunk = blocks << BLK;
         planned[n] = '{KIND_DIRECT, sector, '0, '0, chunk[31:0], dest[31:0], 1'b0};
         n = n + 1;
         left -= chunk;
         dest += chunk;
         sector = sector + 32'(blocks << shift);
      end
      if (left != 0) begin
         slot = cache_lookup(sector, kind);
         planned[n] = '{kind, sector, slot, '0, left[31:0], dest[31:0], 1'b0};
         n = n + 1;
      end
      planned[n-1].last = 1'b1;
      return n;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_FS_SIZE:     fs_size = data;
         CSR_SECTOR_BITS: sect_bits = data[SBITS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // hold start until the request is taken, then queue its expected segments
   task automatic issue(input logic [ADDR_W-1:0] pos, input logic [ADDR_W-1:0] count,
                        input bit typed, input segment_type want);
      int n;
      int i;
      start <= 1'b1;
      req_byte_pos <= pos;
      req_byte_count <= count;
      do @(posedge clock); while (busy);
      n = plan_read(pos, count);
      if (typed)
         pending_segs.push_back(want);
      else
         for (i = 0; i < n; i++) pending_segs.push_back(planned[i]);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_segs.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic dir_req(input logic [ADDR_W-1:0] pos, input logic [ADDR_W-1:0] count);
      dir_rows.push_back('{1'b0, '0, pos, count, 1'b0, '0});
   endtask

   // one-result row whose answer is typed in; dest is 0 and last is set
   task automatic dir_chk(input logic [ADDR_W-1:0] pos, input logic [ADDR_W-1:0] count,
                          input seg_kind_type kind, input logic [ADDR_W-1:0] sector,
                          input logic [SLOT_W-1:0] slot, input logic [BOFF_W-1:0] boff,
                          input logic [ADDR_W-1:0] len);
      dir_rows.push_back('{1'b0, '0, pos, count, 1'b1,
                           '{kind, sector, slot, boff, len, 32'd0, 1'b1}});
   endtask

   task automatic dir_cfg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      dir_rows.push_back('{1'b1, idx, data, '0, 1'b0, '0});
   endtask

   always @(posedge clock) begin
      segment_type got;
      segment_type want;
      if (!reset && rsp_valid) begin
         got = '{seg_kind_type'(rsp_segment_kind), rsp_device_sector, rsp_cache_slot,
                 rsp_block_offset, rsp_seg_length, rsp_dest_offset, rsp_last};
         if (pending_segs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected: kind %0d sector %h slot %0d boff %h len %h dest %h last %b",
                        got.kind, got.sector, got.slot, got.boff, got.len, got.dest, got.last);
         end else begin
            want = pending_segs.pop_front();
            if (got.kind != want.kind || got.sector != want.sector || got.slot != want.slot ||
                got.boff != want.boff || got.len != want.len || got.dest != want.dest ||
                got.last != want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("segment mismatch at %0t", $realtime);
                  $display("  expected kind %0d sector %h slot %0d boff %h len %h dest %h last %b",
                           want.kind, want.sector, want.slot, want.boff, want.len, want.dest,
                           want.last);
                  $display("  actual   kind %0d sector %h slot %0d boff %h len %h dest %h last %b",
                           got.kind, got.sector, got.slot, got.boff, got.len, got.dest,
                           got.last);
               end
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int i, ph, k, nitems, sel;
      logic [ADDR_W-1:0] fs_val, sb_word, base, pos, count;
      bit quiet;
      dir_row_type row;

      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_byte_pos = '0;
      req_byte_count = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_FS_SIZE;
      csr_wdata = '0;
      mismatches = 0;
      fs_size = '0;
      sect_bits = 4'd9;
      fill_ptr = 0;
      for (i = 0; i < ENTRIES; i++) begin
         tag_store[i] = '0;
         tag_valid[i] = 1'b0;
      end

      // size is 0 after reset: every request is empty
      dir_chk(32'd0, 32'd0, KIND_EMPTY, 0, 0, 0, 0);
      dir_chk(32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_EMPTY, 0, 0, 0, 0);
      dir_chk(32'd0, 32'd1, KIND_EMPTY, 0, 0, 0, 0);
      dir_cfg(CSR_FS_SIZE, 32'hFFFF_FFFF);
      dir_chk(32'h1000, 32'h1000, KIND_DIRECT, 32'd8, 0, 0, 32'h1000);
      dir_chk(32'd1, 32'd1, KIND_FILL, 32'd0, 3'd0, 12'd1, 32'd1);
      dir_chk(32'd2, 32'hFFE, KIND_HIT, 32'd0, 3'd0, 12'd2, 32'hFFE);
      dir_chk(32'hFFFF_FFFF, 32'd1, KIND_EMPTY, 0, 0, 0, 0);
      dir_chk(32'd5, 32'd0, KIND_EMPTY, 0, 0, 0, 0);
      dir_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      dir_req(32'd0, 32'hFFFF_FFFF);
      dir_req(32'h123, 32'h3000);
      dir_cfg(CSR_SECTOR_BITS, 32'd12);
      dir_req(32'h2FFF, 32'h2002);
      dir_req(32'h3000, 32'h1);
      // sector larger than a block clamps to the block size
      dir_cfg(CSR_SECTOR_BITS, 32'd15);
      dir_req(32'h5800, 32'h900);
      dir_cfg(CSR_SECTOR_BITS, 32'd0);
      dir_req(32'hFFFF_F000, 32'h1000);
      dir_req(32'h7FF, 32'h1);
      dir_cfg(CSR_FS_SIZE, 32'h3001);
      dir_cfg(CSR_SECTOR_BITS, 32'd9);
      dir_req(32'h3000, 32'h10);
      dir_chk(32'h3001, 32'd1, KIND_EMPTY, 0, 0, 0, 0);
      dir_req(32'h2800, 32'hFFFF_FFFF);
      // writes past the register list are dropped
      dir_cfg(CSR_SPARE_2, 32'hA5A5_5A5A);
      dir_cfg(CSR_SPARE_3, 32'hFFFF_FFFF);
      dir_req(32'h10, 32'h20);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_cfg) begin
            drain();
            csr_write(row.idx, row.a);
         end else begin
            issue(row.a, row.b, row.typed, row.want);
         end
      end

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin fs_val = 32'hFFFF_FFFF; sb_word = 32'd9; end
            1: begin fs_val = $urandom | 32'h0010_0000; sb_word = $urandom_range(9, 12); end
            2: begin fs_val = 32'h0001_8000 + $urandom_range(0, 4095); sb_word = 32'd12; end
            3: begin fs_val = 32'hFFFF_FFFF; sb_word = {28'($urandom() >> 4), 4'hF}; end
            4: begin fs_val = 32'd0; sb_word = 32'd10; end
            default: begin fs_val = $urandom; sb_word = $urandom_range(0, 15); end
         endcase
         drain();
         csr_write(CSR_FS_SIZE, fs_val);
         csr_write(CSR_SECTOR_BITS, sb_word);
         if (ph == 1 || ph == 4) csr_write($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                                           $urandom);
         if (ph == 3)
            base = 32'hFFFF_2000;
         else if (fs_val >= 32'h0002_0000)
            base = $urandom_range(0, (fs_val - 32'h0001_0000) >> 12) << 12;
         else
            base = 32'd0;
         nitems = (fs_val == 0) ? 20 : 80;
         quiet = (ph == 5);
         for (k = 0; k < nitems; k++) begin
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
               // small pool of blocks so tags repeat and slots get recycled
               pos = base + ($urandom_range(0, 11) << 12) + $urandom_range(0, 4095);
               if ($urandom_range(0, 3) == 0) pos[BLK-1:0] = '0;
               count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h6000)
                                                   : $urandom_range(1, 32'h1400);
            end else if (sel == 6) begin
               pos = $urandom;
               count = $urandom;
            end else if (sel == 7) begin
               pos = fs_val - $urandom_range(1, 32'h2000);
               count = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3000);
            end else if (sel == 8) begin
               pos = fs_val + $urandom_range(0, 2);
               count = $urandom;
            end else begin
               pos = base + $urandom_range(0, 32'h3000);
               count = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
            end
            issue(pos, count, 1'b0, '0);
            if (k == 40) begin
               drain();
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end
         end
      end

      start <= 1'b0;
      while (pending_segs.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatches == 0 && pending_segs.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
